@@ rtl/core/irsfd_pkg.sv @@
// ----------------------------------------------------------------------------
// irsfd_pkg
// Beat types, header bytes and the byte-wide CRC-16/CCITT-FALSE step shared by
// the strength frame decoder.
// ----------------------------------------------------------------------------
package irsfd_pkg;

	localparam logic [7:0]  HDR_FIRST  = 8'hA5;
	localparam logic [7:0]  HDR_SECOND = 8'h5A;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'h1021;
	localparam logic [15:0] CRC_TOP    = 16'h8000;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [47:0] time_ms;
	} in_beat_t;

	typedef struct packed {
		logic [7:0]  sequence_res;
		logic [3:0]  channel;
		logic [15:0] strength;
		logic [47:0] stamp_ms;
		logic        last;
	} out_beat_t;

	// msb-first crc over one byte, eight shift steps
	function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
			input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_TOP) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

@@ rtl/core/ir_strength_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// ir_strength_frame_decoder
// Deframes a serial byte stream (A5 5A header, sequence, strength words,
// CRC-16/CCITT-FALSE) and emits one result beat per channel of a good frame.
// ----------------------------------------------------------------------------
//
//  channel | valid      | stall      | payload                     | dir
//  --------+------------+------------+-----------------------------+-----
//  byte    | byte_valid | byte_stall | byte_data (in_beat_t)       | in
//  res     | res_valid  | res_stall  | res_data  (out_beat_t)      | out
//
//  the crc step of a received byte is done as the byte is accepted
//  the byte that completes a good frame starts emission: for each channel
//  the strength memories are read (ST_READ), then the output register is
//  loaded (ST_LOAD), which waits while res_stall holds the previous beat
//  byte_stall is high during emission; the output register holds a beat
//  while res_stall is high
//  reset clears the frame counter, crc and fsm; strength memories are not reset
// ----------------------------------------------------------------------------
module ir_strength_frame_decoder #(
	parameter int NUM_CHANNELS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  irsfd_pkg::in_beat_t  byte_data,
	output logic                 res_valid,
	input  logic                 res_stall,
	output irsfd_pkg::out_beat_t res_data
);

	localparam int PAYLOAD_BYTES = 2 * NUM_CHANNELS;
	localparam int CRC_SPAN      = 3 + PAYLOAD_BYTES;
	localparam int FRAME_BYTES   = CRC_SPAN + 2;
	localparam int POS_W         = $clog2(FRAME_BYTES);
	localparam int CH_W          = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	localparam logic [POS_W-1:0] POS_HDR1  = POS_W'(0);
	localparam logic [POS_W-1:0] POS_HDR2  = POS_W'(1);
	localparam logic [POS_W-1:0] POS_SEQ   = POS_W'(2);
	localparam logic [POS_W-1:0] POS_DATA  = POS_W'(3);
	localparam logic [POS_W-1:0] POS_CRCLO = POS_W'(CRC_SPAN);
	localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_BYTES - 1);
	localparam logic [CH_W-1:0]  CH_LAST   = CH_W'(NUM_CHANNELS - 1);

	typedef enum logic [1:0] {
		ST_RX,
		ST_READ,
		ST_LOAD
	} state_t;

	state_t               state_q;
	logic [POS_W-1:0]     byte_count_q;
	logic [15:0]          crc_q;
	logic [7:0]           seq_q;
	logic [7:0]           crc_lo_q;
	logic [47:0]          stamp_q;
	logic [CH_W-1:0]      ch_q;
	logic                 res_valid_q;
	irsfd_pkg::out_beat_t res_data_q;

	// strength bytes, low and high byte of each channel in separate banks
	logic [7:0]           mem_lo [NUM_CHANNELS];
	logic [7:0]           mem_hi [NUM_CHANNELS];
	logic [7:0]           rd_lo_q;
	logic [7:0]           rd_hi_q;

	logic                 accept;
	logic [7:0]           b;
	logic [15:0]          crc_next;
	logic [15:0]          crc_first;
	logic [POS_W-1:0]     pay_idx;
	logic                 wr_en;
	logic [CH_W-1:0]      wr_addr;
	logic                 rd_en;
	logic                 out_free;

	assign byte_stall = (state_q != ST_RX);
	assign accept     = byte_valid && !byte_stall;
	assign b          = byte_data.data_byte;
	assign crc_next   = irsfd_pkg::crc_update(crc_q, b);
	assign crc_first  = irsfd_pkg::crc_update(irsfd_pkg::CRC_INIT, b);
	assign pay_idx    = byte_count_q - POS_DATA;
	assign wr_addr    = CH_W'(pay_idx >> 1);
	assign wr_en      = accept && (byte_count_q >= POS_DATA) && (byte_count_q < POS_CRCLO);
	assign rd_en      = (state_q == ST_READ);
	assign out_free   = !res_valid_q || !res_stall;

	assign res_valid  = res_valid_q;
	assign res_data   = res_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (pay_idx[0]) begin
				mem_hi[wr_addr] <= b;
			end else begin
				mem_lo[wr_addr] <= b;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_lo_q <= mem_lo[ch_q];
			rd_hi_q <= mem_hi[ch_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_RX;
			byte_count_q <= '0;
			crc_q        <= irsfd_pkg::CRC_INIT;
			seq_q        <= '0;
			crc_lo_q     <= '0;
			stamp_q      <= '0;
			ch_q         <= '0;
			res_valid_q  <= 1'b0;
			res_data_q   <= '0;
		end else begin
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_RX: begin
					if (accept) begin
						if (byte_count_q == POS_HDR1) begin
							if (b == irsfd_pkg::HDR_FIRST) begin
								crc_q        <= crc_first;
								byte_count_q <= POS_HDR2;
							end
						end else if (byte_count_q == POS_HDR2) begin
							if (b == irsfd_pkg::HDR_SECOND) begin
								crc_q        <= crc_next;
								byte_count_q <= POS_SEQ;
							end else if (b == irsfd_pkg::HDR_FIRST) begin
								// a repeated A5 may open a new frame
								crc_q        <= crc_first;
								byte_count_q <= POS_HDR2;
							end else begin
								crc_q        <= irsfd_pkg::CRC_INIT;
								byte_count_q <= POS_HDR1;
							end
						end else if (byte_count_q < POS_CRCLO) begin
							if (byte_count_q == POS_SEQ) begin
								seq_q <= b;
							end
							crc_q        <= crc_next;
							byte_count_q <= byte_count_q + POS_W'(1);
						end else if (byte_count_q == POS_CRCLO) begin
							crc_lo_q     <= b;
							byte_count_q <= byte_count_q + POS_W'(1);
						end else begin
							byte_count_q <= POS_HDR1;
							crc_q        <= irsfd_pkg::CRC_INIT;
							if ({b, crc_lo_q} == crc_q) begin
								stamp_q <= byte_data.time_ms;
								ch_q    <= '0;
								state_q <= ST_READ;
							end
						end
					end
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (out_free) begin
						res_valid_q             <= 1'b1;
						res_data_q.sequence_res <= seq_q;
						res_data_q.channel      <= 4'(ch_q);
						res_data_q.strength     <= {rd_hi_q, rd_lo_q};
						res_data_q.stamp_ms     <= stamp_q;
						res_data_q.last         <= (ch_q == CH_LAST);
						if (ch_q == CH_LAST) begin
							state_q <= ST_RX;
						end else begin
							ch_q    <= ch_q + CH_W'(1);
							state_q <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_RX;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= POS_LAST)
		else $error("frame byte counter past the last frame byte");

	a_idle_crc: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_count_q == POS_HDR1) |-> (crc_q == irsfd_pkg::CRC_INIT))
		else $error("crc not at its initial value while hunting");

	a_emit_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ && $past(state_q) == ST_RX) |->
			($past(byte_count_q) == POS_LAST && $past(accept) && byte_count_q == POS_HDR1))
		else $error("emission started without a completed frame");

	a_last_channel: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_data_q.last) |-> (res_data_q.channel == 4'(NUM_CHANNELS - 1)))
		else $error("last flag on a channel other than the final one");
`endif

endmodule
